FILE: sv/ctsm_pkg.sv
`default_nettype none
package ctsm_pkg;

    localparam int SHIFT_W     = 24;
    localparam int TURN_W      = 20;
    localparam int PATH_W      = 48;
    localparam int SUM_W       = 56;
    localparam int PATH_ROW_W  = 3 * PATH_W;
    localparam int MOT_ROW_W   = 2 * SHIFT_W + TURN_W;
    localparam int RADIUS_DEF  = 50;
    localparam int RADIUS_MAX  = 63;
    localparam int PADDR_MAX_W = $clog2(2 * RADIUS_MAX + 1);
    localparam int MADDR_MAX_W = $clog2(RADIUS_MAX + 1);
    localparam int AGE_MAX_W   = $clog2(RADIUS_MAX + 1);
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic signed [TURN_W-1:0]  turn;
        logic                      final_frame;
    } t_in;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] fixed_x;
        logic signed [SHIFT_W-1:0] fixed_y;
        logic signed [TURN_W-1:0]  fixed_turn;
        logic                      end_of_run;
    } t_out;

    typedef struct packed {
        logic [PADDR_MAX_W-1:0] phead;
        logic [MADDR_MAX_W-1:0] mhead;
        logic [AGE_MAX_W-1:0]   age;
        logic [AGE_MAX_W-1:0]   back;
        logic                   last;
    } t_job;

    typedef struct packed {
        logic busy;
        logic empty;
        logic full;
    } t_flow;

    typedef enum logic {
        F_IDLE,
        F_ISSUE
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM,
        B_TAIL,
        B_LOAD,
        B_DIV,
        B_FIX
    } t_back_state;

endpackage
`default_nettype wire

FILE: sv/ctsm_ram.sv
`default_nettype none
module ctsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/ctsm_queue.sv
`default_nettype none
module ctsm_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ctsm_pkg::t_job i_job,
    input  wire logic          i_pop,
    output ctsm_pkg::t_job     o_job,
    output logic               o_empty,
    output logic               o_full
);
    import ctsm_pkg::*;

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_job           r_slot [QUEUE_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_fill;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == (QAW+1)'(QUEUE_DEPTH));
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_fill <= r_fill + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

FILE: sv/ctsm_front.sv
`default_nettype none
module ctsm_front #(
    parameter int WINDOW_RADIUS = ctsm_pkg::RADIUS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire ctsm_pkg::t_in                         i_data,
    output logic                                       o_ready,
    input  wire ctsm_pkg::t_flow                       i_flow,
    output logic                                       o_push,
    output ctsm_pkg::t_job                             o_job,
    output logic                                       o_we,
    output logic [$clog2(2*WINDOW_RADIUS+1)-1:0]       o_paddr,
    output logic [ctsm_pkg::PATH_ROW_W-1:0]            o_pdata,
    output logic [$clog2(WINDOW_RADIUS+1)-1:0]         o_maddr,
    output logic [ctsm_pkg::MOT_ROW_W-1:0]             o_mdata
);
    import ctsm_pkg::*;

    localparam int PD  = 2 * WINDOW_RADIUS + 1;
    localparam int MD  = WINDOW_RADIUS + 1;
    localparam int PAW = $clog2(PD);
    localparam int MAW = $clog2(MD);
    localparam int SW  = $clog2(2 * WINDOW_RADIUS + 2);

    t_front_state              r_state, n_state;
    logic signed [PATH_W-1:0]  r_px, r_py, r_pt;
    logic signed [PATH_W-1:0]  n_px, n_py, n_pt;
    logic [PAW-1:0]            r_ppos, r_jhead_p;
    logic [MAW-1:0]            r_mpos, r_jhead_m;
    logic [SW-1:0]             r_seen, n_seen, r_jseen;
    logic [AGE_MAX_W-1:0]      r_age;
    logic                      r_fin;
    logic                      accept;
    logic [SW-1:0]             diff;
    logic [SW-1:0]             top;

    function automatic logic signed [PATH_W-1:0] sat_add(
        input logic signed [PATH_W-1:0] a,
        input logic signed [SHIFT_W-1:0] d
    );
        logic signed [PATH_W:0] s;
        s = {a[PATH_W-1], a} + (PATH_W+1)'(d);
        if (s[PATH_W] != s[PATH_W-1]) begin
            sat_add = s[PATH_W] ? {1'b1, {(PATH_W-1){1'b0}}} : {1'b0, {(PATH_W-1){1'b1}}};
        end else begin
            sat_add = s[PATH_W-1:0];
        end
    endfunction

    assign accept = i_valid & o_ready;
    assign n_px   = sat_add(r_px, i_data.shift_x);
    assign n_py   = sat_add(r_py, i_data.shift_y);
    assign n_pt   = sat_add(r_pt, SHIFT_W'(i_data.turn));
    assign n_seen = (r_seen == SW'(PD)) ? r_seen : r_seen + 1'b1;
    assign top    = ((n_seen - 1'b1) > SW'(WINDOW_RADIUS)) ? SW'(WINDOW_RADIUS)
                                                           : n_seen - 1'b1;
    assign diff   = r_jseen - 1'b1 - SW'(r_age);

    assign o_we    = accept;
    assign o_paddr = r_ppos;
    assign o_maddr = r_mpos;
    assign o_pdata = {n_pt, n_py, n_px};
    assign o_mdata = {i_data.turn, i_data.shift_y, i_data.shift_x};

    always_comb begin
        o_job.phead = PADDR_MAX_W'(r_jhead_p);
        o_job.mhead = MADDR_MAX_W'(r_jhead_m);
        o_job.age   = r_age;
        o_job.back  = (diff > SW'(WINDOW_RADIUS)) ? AGE_MAX_W'(WINDOW_RADIUS)
                                                  : AGE_MAX_W'(diff);
        o_job.last  = r_fin && (r_age == '0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept && (i_data.final_frame || n_seen > SW'(WINDOW_RADIUS))) begin
                    n_state = F_ISSUE;
                end
            end
            F_ISSUE: begin
                if (!i_flow.full && (!r_fin || r_age == '0)) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE:  o_ready = i_flow.empty && !i_flow.busy;
            F_ISSUE: o_push  = !i_flow.full;
            default: o_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_px      <= '0;
            r_py      <= '0;
            r_pt      <= '0;
            r_ppos    <= '0;
            r_mpos    <= '0;
            r_seen    <= '0;
            r_jseen   <= '0;
            r_jhead_p <= '0;
            r_jhead_m <= '0;
            r_age     <= '0;
            r_fin     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_jhead_p <= r_ppos;
                r_jhead_m <= r_mpos;
                r_jseen   <= n_seen;
                if (i_data.final_frame) begin
                    r_fin  <= 1'b1;
                    r_age  <= AGE_MAX_W'(top);
                    r_px   <= '0;
                    r_py   <= '0;
                    r_pt   <= '0;
                    r_seen <= '0;
                    r_ppos <= '0;
                    r_mpos <= '0;
                end else begin
                    r_fin  <= 1'b0;
                    r_age  <= AGE_MAX_W'(WINDOW_RADIUS);
                    r_px   <= n_px;
                    r_py   <= n_py;
                    r_pt   <= n_pt;
                    r_seen <= n_seen;
                    r_ppos <= (r_ppos == PAW'(PD - 1)) ? '0 : r_ppos + 1'b1;
                    r_mpos <= (r_mpos == MAW'(MD - 1)) ? '0 : r_mpos + 1'b1;
                end
            end else if (o_push && r_age != '0) begin
                r_age <= r_age - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/ctsm_back.sv
`default_nettype none
module ctsm_back #(
    parameter int WINDOW_RADIUS = ctsm_pkg::RADIUS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_q_empty,
    input  wire ctsm_pkg::t_job                        i_job,
    output logic                                       o_pop,
    output logic                                       o_busy,
    output logic [$clog2(2*WINDOW_RADIUS+1)-1:0]       o_praddr,
    input  wire logic [ctsm_pkg::PATH_ROW_W-1:0]       i_prdata,
    output logic [$clog2(WINDOW_RADIUS+1)-1:0]         o_mraddr,
    input  wire logic [ctsm_pkg::MOT_ROW_W-1:0]        i_mrdata,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output ctsm_pkg::t_out                             o_data
);
    import ctsm_pkg::*;

    localparam int PD    = 2 * WINDOW_RADIUS + 1;
    localparam int MD    = WINDOW_RADIUS + 1;
    localparam int PAW   = $clog2(PD);
    localparam int MAW   = $clog2(MD);
    localparam int CW    = $clog2(2 * WINDOW_RADIUS + 2);
    localparam int DCW   = $clog2(SUM_W);
    localparam int FIX_W = SUM_W + 2;

    t_back_state               r_state, n_state;
    t_job                      r_job;
    logic [PAW-1:0]            r_addr;
    logic [MAW-1:0]            r_maddr;
    logic [CW-1:0]             r_k, r_span, r_cnt;
    logic                      r_rd_vld, r_rd_hit;
    logic signed [SUM_W-1:0]   r_sum [3];
    logic signed [PATH_W-1:0]  r_self [3];
    logic [SUM_W-1:0]          r_dq [3];
    logic [CW-1:0]             r_rem [3];
    logic                      r_neg [3];
    logic [MOT_ROW_W-1:0]      r_mot;
    logic [DCW-1:0]            r_dcnt;
    logic                      load_out;
    logic [CW-1:0]             span;
    logic [MAW:0]              mdiff;
    logic signed [FIX_W-1:0]   corr [3];
    logic signed [FIX_W-1:0]   mot_s [3];
    t_out                      res;

    assign span  = CW'(i_job.age) + CW'(i_job.back);
    assign mdiff = (MAW+1)'(i_job.mhead) - (MAW+1)'(i_job.age);
    assign o_praddr = r_addr;
    assign o_mraddr = r_maddr;
    assign load_out = !o_valid || i_ready;

    assign mot_s[0] = FIX_W'($signed(r_mot[SHIFT_W-1:0]));
    assign mot_s[1] = FIX_W'($signed(r_mot[2*SHIFT_W-1:SHIFT_W]));
    assign mot_s[2] = FIX_W'($signed(r_mot[MOT_ROW_W-1:2*SHIFT_W]));

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            corr[i] = mot_s[i]
                    + (r_neg[i] ? -FIX_W'($signed({1'b0, r_dq[i]}))
                                :  FIX_W'($signed({1'b0, r_dq[i]})))
                    - FIX_W'(r_self[i]);
        end
        if (&corr[0][FIX_W-1:SHIFT_W-1] || ~|corr[0][FIX_W-1:SHIFT_W-1]) begin
            res.fixed_x = corr[0][SHIFT_W-1:0];
        end else begin
            res.fixed_x = {corr[0][FIX_W-1], {(SHIFT_W-1){~corr[0][FIX_W-1]}}};
        end
        if (&corr[1][FIX_W-1:SHIFT_W-1] || ~|corr[1][FIX_W-1:SHIFT_W-1]) begin
            res.fixed_y = corr[1][SHIFT_W-1:0];
        end else begin
            res.fixed_y = {corr[1][FIX_W-1], {(SHIFT_W-1){~corr[1][FIX_W-1]}}};
        end
        if (&corr[2][FIX_W-1:TURN_W-1] || ~|corr[2][FIX_W-1:TURN_W-1]) begin
            res.fixed_turn = corr[2][TURN_W-1:0];
        end else begin
            res.fixed_turn = {corr[2][FIX_W-1], {(TURN_W-1){~corr[2][FIX_W-1]}}};
        end
        res.end_of_run = r_job.last;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_q_empty) n_state = B_SUM;
            B_SUM:  if (r_k == r_span) n_state = B_TAIL;
            B_TAIL: n_state = B_LOAD;
            B_LOAD: n_state = B_DIV;
            B_DIV:  if (r_dcnt == DCW'(SUM_W - 1)) n_state = B_FIX;
            B_FIX:  if (load_out) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        o_busy = 1'b1;
        unique case (r_state)
            B_IDLE: begin
                o_pop  = !i_q_empty;
                o_busy = 1'b0;
            end
            default: o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        logic [CW:0] rsh;
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_rd_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == B_SUM);
            if (r_state == B_FIX && load_out) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
        if (r_state == B_FIX && load_out) begin
            o_data <= res;
        end
        unique case (r_state)
            B_IDLE: begin
                r_job  <= i_job;
                r_addr <= PAW'(i_job.phead);
                r_k    <= '0;
                r_span <= span;
                r_cnt  <= span + 1'b1;
                r_maddr <= mdiff[MAW] ? MAW'(mdiff + (MAW+1)'(MD)) : MAW'(mdiff);
                for (int i = 0; i < 3; i++) begin
                    r_sum[i] <= '0;
                end
            end
            B_SUM: begin
                r_addr <= (r_addr == '0) ? PAW'(PD - 1) : r_addr - 1'b1;
                r_k    <= r_k + 1'b1;
            end
            B_TAIL: r_mot <= i_mrdata;
            B_LOAD: begin
                r_dcnt <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_neg[i] <= r_sum[i][SUM_W-1];
                    r_dq[i]  <= r_sum[i][SUM_W-1] ? SUM_W'(-r_sum[i]) : SUM_W'(r_sum[i]);
                    r_rem[i] <= '0;
                end
            end
            B_DIV: begin
                r_dcnt <= r_dcnt + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    rsh = {r_rem[i], r_dq[i][SUM_W-1]};
                    if (rsh >= {1'b0, r_cnt}) begin
                        r_rem[i] <= CW'(rsh - {1'b0, r_cnt});
                        r_dq[i]  <= {r_dq[i][SUM_W-2:0], 1'b1};
                    end else begin
                        r_rem[i] <= CW'(rsh);
                        r_dq[i]  <= {r_dq[i][SUM_W-2:0], 1'b0};
                    end
                end
            end
            default: r_dcnt <= r_dcnt;
        endcase
        r_rd_hit <= (r_k == CW'(r_job.age));
        if (r_rd_vld) begin
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= r_sum[i] + SUM_W'($signed(i_prdata[i*PATH_W +: PATH_W]));
                if (r_rd_hit) begin
                    r_self[i] <= $signed(i_prdata[i*PATH_W +: PATH_W]);
                end
            end
        end
    end

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SUM) |-> (r_k <= r_span))
        else $error("window read ran past its span");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_empty)
        else $error("pop from an empty queue");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV && r_dcnt == DCW'(SUM_W - 1)) |=> (r_state == B_FIX))
        else $error("divider did not finish on its last step");
    a_out_from_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == B_FIX))
        else $error("result appeared without a finished frame");
endmodule
`default_nettype wire

FILE: sv/camera_trajectory_smoother.sv
// Channel  Valid    Ready    Payload  Transaction
// input    i_valid  o_ready  i_data   one motion estimate (t_in)
// output   o_valid  i_ready  o_data   one corrected frame (t_out)
//
// Each result reads a window of span+1 rows from the path RAM, then runs the
// sums through the radix-2 divider; span is up to twice the window radius.
// A new estimate is taken once every queued frame has been carried out.
// Reset is synchronous; the history RAMs are not cleared and need no sweep.
// The output register lets the back end finish the next frame while a
// transaction waits on i_ready.
`default_nettype none
module camera_trajectory_smoother #(
    parameter int WINDOW_RADIUS = ctsm_pkg::RADIUS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire ctsm_pkg::t_in i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output ctsm_pkg::t_out     o_data
);
    import ctsm_pkg::*;

    localparam int PD  = 2 * WINDOW_RADIUS + 1;
    localparam int MD  = WINDOW_RADIUS + 1;
    localparam int PAW = $clog2(PD);
    localparam int MAW = $clog2(MD);

    t_flow                 flow;
    t_job                  push_job, pop_job;
    logic                  push, pop, we, busy, q_empty, q_full;
    logic [PAW-1:0]        paddr, praddr;
    logic [MAW-1:0]        maddr, mraddr;
    logic [PATH_ROW_W-1:0] pdata, prdata;
    logic [MOT_ROW_W-1:0]  mdata, mrdata;

    assign flow.busy  = busy;
    assign flow.empty = q_empty;
    assign flow.full  = q_full;

    ctsm_front #(.WINDOW_RADIUS(WINDOW_RADIUS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_data(i_data), .o_ready(o_ready),
        .i_flow(flow), .o_push(push), .o_job(push_job),
        .o_we(we), .o_paddr(paddr), .o_pdata(pdata),
        .o_maddr(maddr), .o_mdata(mdata)
    );

    ctsm_ram #(.WIDTH(PATH_ROW_W), .DEPTH(PD)) u_path_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(paddr), .i_wdata(pdata),
        .i_raddr(praddr), .o_rdata(prdata)
    );

    ctsm_ram #(.WIDTH(MOT_ROW_W), .DEPTH(MD)) u_motion_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(maddr), .i_wdata(mdata),
        .i_raddr(mraddr), .o_rdata(mrdata)
    );

    ctsm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_job(push_job), .i_pop(pop),
        .o_job(pop_job), .o_empty(q_empty), .o_full(q_full)
    );

    ctsm_back #(.WINDOW_RADIUS(WINDOW_RADIUS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_empty(q_empty), .i_job(pop_job), .o_pop(pop), .o_busy(busy),
        .o_praddr(praddr), .i_prdata(prdata),
        .o_mraddr(mraddr), .i_mrdata(mrdata),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );
endmodule
`default_nettype wire

FILE: tb/camera_trajectory_smoother_test.sv
`default_nettype none
module camera_trajectory_smoother_test;
    import ctsm_pkg::*;

    localparam int RADIUS = RADIUS_DEF;
    localparam int PDEPTH = 2 * RADIUS + 1;
    localparam int MDEPTH = RADIUS + 1;
    localparam int IDLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in i_data = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    camera_trajectory_smoother #(.WINDOW_RADIUS(RADIUS)) u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic signed [47:0] trail_x, trail_y, trail_turn;
    logic signed [47:0] trail_hist_x [PDEPTH];
    logic signed [47:0] trail_hist_y [PDEPTH];
    logic signed [47:0] trail_hist_turn [PDEPTH];
    t_in motion_hist [MDEPTH];
    int unsigned frame_count;
    int unsigned trail_head;
    int unsigned motion_head;

    t_out corrected_q[$];
    int errors = 0;
    int quiet_cycles = 0;
    logic long_hold = 1'b0;
    int burst_left = 0;
    int gap_left = 0;

    function automatic logic signed [47:0] sat48(logic signed [48:0] v);
        if (v > 49'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < -49'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic logic signed [63:0] clip_to(logic signed [63:0] v, int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic void clear_trail();
        trail_x = '0;
        trail_y = '0;
        trail_turn = '0;
        frame_count = 0;
        trail_head = 0;
        motion_head = 0;
    endfunction

    function automatic t_out correct_frame(int unsigned age, logic last);
        int unsigned back;
        int unsigned span;
        int unsigned k;
        int unsigned pi;
        int unsigned mi;
        logic signed [63:0] sx, sy, st, cnt;
        t_out r;
        sx = 0;
        sy = 0;
        st = 0;
        back = frame_count - 1 - age;
        if (back > RADIUS) back = RADIUS;
        span = age + back;
        for (int unsigned a = 0; a <= span; a++) begin
            k = (trail_head + PDEPTH - (a % PDEPTH)) % PDEPTH;
            sx += trail_hist_x[k];
            sy += trail_hist_y[k];
            st += trail_hist_turn[k];
        end
        cnt = span + 1;
        pi = (trail_head + PDEPTH - age) % PDEPTH;
        mi = (motion_head + MDEPTH - age) % MDEPTH;
        r.fixed_x = 24'(clip_to(64'(motion_hist[mi].shift_x) + sx / cnt
            - trail_hist_x[pi], 24));
        r.fixed_y = 24'(clip_to(64'(motion_hist[mi].shift_y) + sy / cnt
            - trail_hist_y[pi], 24));
        r.fixed_turn = 20'(clip_to(64'(motion_hist[mi].turn) + st / cnt
            - trail_hist_turn[pi], 20));
        r.end_of_run = last;
        return r;
    endfunction

    function automatic void predict_frame(t_in d);
        int unsigned top;
        trail_x = sat48(49'(trail_x) + 49'(d.shift_x));
        trail_y = sat48(49'(trail_y) + 49'(d.shift_y));
        trail_turn = sat48(49'(trail_turn) + 49'(d.turn));
        trail_hist_x[trail_head] = trail_x;
        trail_hist_y[trail_head] = trail_y;
        trail_hist_turn[trail_head] = trail_turn;
        motion_hist[motion_head] = d;
        if (frame_count < 65535) frame_count++;
        if (!d.final_frame) begin
            if (frame_count - 1 >= RADIUS)
                corrected_q = {corrected_q, correct_frame(RADIUS, 1'b0)};
            trail_head = (trail_head + 1) % PDEPTH;
            motion_head = (motion_head + 1) % MDEPTH;
        end else begin
            top = frame_count - 1;
            if (top > RADIUS) top = RADIUS;
            for (int a = top; a >= 0; a--)
                corrected_q = {corrected_q, correct_frame(a, a == 0)};
            clear_trail();
        end
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // The sender drives frames in bursts with idle gaps between them.
    task automatic send_frame(t_in d);
        if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            burst_left = $urandom_range(1, 8);
        end
        while (gap_left > 0) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            gap_left--;
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data <= d;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_frame(d);
    endtask

    function automatic t_in rand_frame(logic fin);
        t_in d;
        case ($urandom_range(0, 3))
            0: begin
                d.shift_x = 24'($urandom);
                d.shift_y = 24'($urandom);
                d.turn = 20'($urandom);
            end
            1: begin
                d.shift_x = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                d.shift_y = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                d.turn = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
            end
            default: begin
                d.shift_x = 24'(int'($urandom_range(0, 2000)) - 1000);
                d.shift_y = 24'(int'($urandom_range(0, 2000)) - 1000);
                d.turn = 20'(int'($urandom_range(0, 600)) - 300);
            end
        endcase
        d.final_frame = fin;
        return d;
    endfunction

    task automatic send_run(int n);
        for (int i = 0; i < n; i++) send_frame(rand_frame(i == n - 1));
    endtask

    task automatic test_extremes();
        t_in d;
        d = '{shift_x: 24'h7FFFFF, shift_y: 24'h800000, turn: 20'h7FFFF, final_frame: 1'b0};
        send_frame(d);
        d = '{shift_x: 24'h800000, shift_y: 24'h7FFFFF, turn: 20'h80000, final_frame: 1'b0};
        send_frame(d);
        d = '{shift_x: 24'h000000, shift_y: 24'hFFFFFF, turn: 20'h00001, final_frame: 1'b1};
        send_frame(d);
    endtask

    task automatic test_single_frame();
        send_frame('{shift_x: 24'h000123, shift_y: 24'hFFFF00, turn: 20'h00010,
            final_frame: 1'b1});
        send_frame('{shift_x: 24'h7FFFFF, shift_y: 24'h7FFFFF, turn: 20'h7FFFF,
            final_frame: 1'b1});
    endtask

    task automatic test_short_runs();
        send_run(5);
        send_run(RADIUS + 1);
    endtask

    task automatic test_long_run();
        send_run(2 * RADIUS + 20);
    endtask

    task automatic test_saturating_path();
        t_in d;
        d = '{shift_x: 24'h7FFFFF, shift_y: 24'h800000, turn: 20'h7FFFF, final_frame: 1'b0};
        for (int i = 0; i < 8; i++) send_frame(d);
        send_run(4);
    endtask

    task automatic test_backpressure();
        long_hold <= 1'b1;
        send_run(RADIUS + 6);
        long_hold <= 1'b0;
    endtask

    // Checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (corrected_q.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(o_data), '0);
            end else begin
                if (o_data.fixed_x !== corrected_q[0].fixed_x)
                    report_mismatch("fixed_x", 64'(o_data.fixed_x), 64'(corrected_q[0].fixed_x));
                if (o_data.fixed_y !== corrected_q[0].fixed_y)
                    report_mismatch("fixed_y", 64'(o_data.fixed_y), 64'(corrected_q[0].fixed_y));
                if (o_data.fixed_turn !== corrected_q[0].fixed_turn)
                    report_mismatch("fixed_turn", 64'(o_data.fixed_turn),
                        64'(corrected_q[0].fixed_turn));
                if (o_data.end_of_run !== corrected_q[0].end_of_run)
                    report_mismatch("end_of_run", 64'(o_data.end_of_run),
                        64'(corrected_q[0].end_of_run));
                void'(corrected_q.pop_front());
            end
        end
    end

    // Receiver stall pattern, with a long hold-off when requested.
    int hold_count = 0;
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (long_hold && hold_count < 3000) begin
            hold_count <= hold_count + 1;
            i_ready <= 1'b0;
        end else begin
            stall_phase <= (stall_phase + 1) % 64;
            if (stall_phase < 24) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        clear_trail();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_single_frame();
        test_short_runs();
        test_saturating_path();
        test_backpressure();
        test_long_run();
        i_valid <= 1'b0;
        while (corrected_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
